// ===== src/cesu8s2u_pkg.sv =====
// Shared types, constants and byte-class helpers for the CESU-8 surrogate
// pair to UTF-8 converter. No dependencies.
package cesu8s2u_pkg;

   localparam int PAIR_LEN   = 6;
   localparam int HELD_DEPTH = 5;
   localparam int CNT_W      = 3;

   localparam logic [7:0] LEAD_BYTE  = 8'hED;
   localparam logic [7:0] HI_MIN     = 8'hA0;
   localparam logic [7:0] HI_MAX     = 8'hAF;
   localparam logic [7:0] LO_MIN     = 8'hB0;
   localparam logic [7:0] LO_MAX     = 8'hBF;
   localparam logic [7:0] CONT_MIN   = 8'h80;
   localparam logic [7:0] CONT_MAX   = 8'hBF;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [20:0] SUPP_BASE = 21'h10000;

   // What happens to the held bytes plus the new byte
   typedef enum logic [1:0] {
      SCAN_KEEP_ALL,     // still a valid beginning of a pair
      SCAN_RESTART_MID,  // second lead byte of the held run starts a new pair
      SCAN_RESTART_NEW,  // new byte alone starts a new pair
      SCAN_DROP_ALL      // nothing can start a pair
   } scan_kind_type;

   // One queue word: the bytes released by a single input byte
   typedef struct packed {
      logic [PAIR_LEN-1:0][7:0] data;
      logic [CNT_W-1:0]         count;
      logic                     last;
      logic                     status;
   } entry_type;

   // Does byte b fit the pair pattern at position pos?
   function automatic logic fits(input logic [CNT_W-1:0] pos, input logic [7:0] b);
      logic ok;
      case (pos)
         3'd0, 3'd3: ok = (b == LEAD_BYTE);
         3'd1:       ok = b inside {[HI_MIN:HI_MAX]};
         3'd4:       ok = b inside {[LO_MIN:LO_MAX]};
         3'd2, 3'd5: ok = b inside {[CONT_MIN:CONT_MAX]};
         default:    ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

// ===== src/cesu8_surrogate_to_utf8_unit.sv =====
// Top level of the CESU-8 surrogate pair to UTF-8 converter.
// Depends on cesu8s2u_pkg, cesu8s2u_front, cesu8s2u_queue, cesu8s2u_back.
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+---------------------------
//   req     | req_valid/ready, text_byte, end_of_text | one CESU-8 text byte a word
//   rsp     | rsp_valid/ready, out_byte, out_last,    | one UTF-8 byte a word
//           | conv_status                             |
//
// Cycles: one text byte accepted per cycle while the queue has room; one output
// byte leaves per cycle while rsp is ready. A byte that releases n bytes (up to six
// on a broken match or end of text) holds the output register for all n of them;
// the word queue (QUEUE_DEPTH words) absorbs these bursts. A released byte is written
// into the queue, then loaded into the output register, before it shows on rsp.
// Reset clears the match state, queue pointers and output valid; no sweep.
// req_ready drops only while the queue is full; rsp stalls hold the output
// register and back up into the queue.
module cesu8_surrogate_to_utf8_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_conv_status
);

   logic                    accept;
   logic                    push, pop, empty, full;
   cesu8s2u_pkg::entry_type push_entry, head;

   // Take a byte whenever there is room for the word it may produce
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   // Classify: extend, restart or drop the partial match, or convert a pair
   cesu8s2u_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Decouple the two sides so output stalls do not stop the scan at once
   cesu8s2u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   // Serialize each word into output bytes
   cesu8s2u_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_last    (rsp_out_last),
      .rsp_conv_status (rsp_conv_status)
   );

endmodule

// ===== src/cesu8s2u_front.sv =====
// Front end: accepts text bytes, tracks the partial surrogate match and
// builds at most one queue word per byte. Depends on cesu8s2u_pkg.
module cesu8s2u_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             text_byte,
   input  logic                   end_of_text,
   output logic                   push,
   output cesu8s2u_pkg::entry_type push_entry
);

   logic [7:0]                      held_ff [cesu8s2u_pkg::HELD_DEPTH];
   logic [7:0]                      held_in [cesu8s2u_pkg::HELD_DEPTH];
   logic [cesu8s2u_pkg::CNT_W-1:0]  held_count_ff, held_count_in;
   logic                            pair_seen_ff, pair_seen_in;

   logic [cesu8s2u_pkg::PAIR_LEN-1:0][7:0] cand;
   logic [cesu8s2u_pkg::CNT_W-1:0]  cand_len, rel_count;
   logic                            fit, pair;
   cesu8s2u_pkg::scan_kind_type     kind;
   logic [9:0]                      hi_bits, lo_bits;
   logic [20:0]                     code_point;

   always_comb begin
      for (int i = 0; i < cesu8s2u_pkg::HELD_DEPTH; i++) begin
         cand[i] = (cesu8s2u_pkg::CNT_W'(i) < held_count_ff) ? held_ff[i] : text_byte;
      end
      cand[cesu8s2u_pkg::PAIR_LEN-1] = text_byte;
      cand_len = held_count_ff + 3'd1;

      fit  = cesu8s2u_pkg::fits(held_count_ff, text_byte);
      pair = fit && (held_count_ff == cesu8s2u_pkg::CNT_W'(cesu8s2u_pkg::HELD_DEPTH));

      // Held run is always a valid prefix; only its lead bytes can restart
      if (fit) begin
         kind      = cesu8s2u_pkg::SCAN_KEEP_ALL;
         rel_count = '0;
      end else if (held_count_ff == 3'd4 &&
                   text_byte inside {[cesu8s2u_pkg::HI_MIN:cesu8s2u_pkg::HI_MAX]}) begin
         kind      = cesu8s2u_pkg::SCAN_RESTART_MID;
         rel_count = 3'd3;
      end else if (text_byte == cesu8s2u_pkg::LEAD_BYTE) begin
         kind      = cesu8s2u_pkg::SCAN_RESTART_NEW;
         rel_count = held_count_ff;
      end else begin
         kind      = cesu8s2u_pkg::SCAN_DROP_ALL;
         rel_count = cand_len;
      end

      hi_bits    = {held_ff[1][3:0], held_ff[2][5:0]};
      lo_bits    = {held_ff[4][3:0], text_byte[5:0]};
      code_point = cesu8s2u_pkg::SUPP_BASE + {1'b0, hi_bits, lo_bits};

      push_entry.last   = end_of_text;
      push_entry.status = ~(pair_seen_ff | pair);
      if (pair) begin
         push_entry.data  = '0;
         push_entry.data[0] = cesu8s2u_pkg::UTF8_LEAD4 | {5'd0, code_point[20:18]};
         push_entry.data[1] = cesu8s2u_pkg::UTF8_CONT  | {2'd0, code_point[17:12]};
         push_entry.data[2] = cesu8s2u_pkg::UTF8_CONT  | {2'd0, code_point[11:6]};
         push_entry.data[3] = cesu8s2u_pkg::UTF8_CONT  | {2'd0, code_point[5:0]};
         push_entry.count   = 3'd4;
      end else begin
         push_entry.data  = cand;
         push_entry.count = end_of_text ? cand_len : rel_count;
      end
      push = accept && (push_entry.count != '0);

      // Advance the held run
      held_in = held_ff;
      case (kind)
         cesu8s2u_pkg::SCAN_KEEP_ALL: begin
            for (int i = 0; i < cesu8s2u_pkg::HELD_DEPTH; i++) begin
               if (cesu8s2u_pkg::CNT_W'(i) == held_count_ff) held_in[i] = text_byte;
            end
         end
         cesu8s2u_pkg::SCAN_RESTART_MID: begin
            held_in[0] = held_ff[3];
            held_in[1] = text_byte;
         end
         cesu8s2u_pkg::SCAN_RESTART_NEW: held_in[0] = text_byte;
         default: ;
      endcase

      if (pair || end_of_text) begin
         held_count_in = '0;
      end else begin
         held_count_in = cand_len - rel_count;
      end
      pair_seen_in = end_of_text ? 1'b0 : (pair_seen_ff | pair);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         pair_seen_ff  <= 1'b0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         pair_seen_ff  <= pair_seen_in;
      end
   end

endmodule

// ===== src/cesu8s2u_queue.sv =====
// Short word queue between the front end and the byte serializer.
// Depends on cesu8s2u_pkg.
module cesu8s2u_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cesu8s2u_pkg::entry_type push_entry,
   input  logic                    pop,
   output cesu8s2u_pkg::entry_type head,
   output logic                    empty,
   output logic                    full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cesu8s2u_pkg::entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   assign head  = store_ff[rd_ptr_ff];
   assign empty = (fill_ff == '0);
   assign full  = (fill_ff == CNT_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== src/cesu8s2u_back.sv =====
// Back end: walks the queue head one byte per cycle, while rsp is not stalled,
// into the output register. Depends on cesu8s2u_pkg.
module cesu8s2u_back (
   input  logic                    clock,
   input  logic                    reset,
   input  cesu8s2u_pkg::entry_type head,
   input  logic                    empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_out_last,
   output logic                    rsp_conv_status
);

   logic [cesu8s2u_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   logic [7:0]                     byte_ff, byte_in;
   logic                           last_ff, last_in;
   logic                           status_ff, status_in;
   logic                           load, at_end;

   always_comb begin
      load      = !empty && (!valid_ff || rsp_ready);
      at_end    = (idx_ff == head.count - 3'd1);
      pop       = load && at_end;
      idx_in    = idx_ff;
      if (load) idx_in = at_end ? '0 : idx_ff + 3'd1;
      valid_in  = load || (valid_ff && !rsp_ready);
      byte_in   = head.data[idx_ff];
      last_in   = head.last && at_end;
      status_in = head.last && at_end && head.status;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_out_last    = last_ff;
   assign rsp_conv_status = status_ff;

endmodule

// ===== src/cesu8s2u_checker.sv =====
// Port-level checks for the converter top level, and the bind that
// attaches them. Depends on cesu8_surrogate_to_utf8_unit.
module cesu8s2u_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last,
   input logic       rsp_conv_status
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_out_last)
                                  && $stable(rsp_conv_status))
      else $error("rsp payload changed while stalled");

   // Status is only reported on the final byte of a text
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_conv_status |-> rsp_out_last)
      else $error("conv_status set on a byte that is not last");

   // Drop all output after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind cesu8_surrogate_to_utf8_unit cesu8s2u_checker u_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for cesu8_surrogate_to_utf8_unit: checks each output byte against a built-in
// surrogate pair converter. Needs only the RTL (the top level and everything it depends on).

module tb;

   // Byte pattern of a CESU-8 surrogate pair: ED A0-AF 80-BF ED B0-BF 80-BF
   localparam int         PAIR_BYTES  = 6;
   localparam int         HOLD_SLOTS  = 5;
   localparam logic [7:0] SURR_LEAD   = 8'hED;
   localparam logic [7:0] HIGH_FIRST  = 8'hA0;
   localparam logic [7:0] HIGH_LAST   = 8'hAF;
   localparam logic [7:0] LOW_FIRST   = 8'hB0;
   localparam logic [7:0] LOW_LAST    = 8'hBF;
   localparam logic [7:0] TRAIL_FIRST = 8'h80;
   localparam logic [7:0] TRAIL_LAST  = 8'hBF;
   localparam int unsigned HIGH_BASE  = 32'hD800;
   localparam int unsigned LOW_BASE   = 32'hDC00;
   localparam int unsigned SUPP_START = 32'h10000;
   localparam int unsigned HALF_SPAN  = 32'h400;

   // One word on the output channel
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       status;
   } utf8_word_type;

   // One word on the input channel
   typedef struct packed {
      logic [7:0] data;
      logic       eot;
   } text_word_type;

   // Tracks the converter's match state and holds the UTF-8 bytes still owed.
   class utf8_scoreboard_type;
      logic [7:0]    held [HOLD_SLOTS];
      int            held_n;
      bit            pair_seen;
      utf8_word_type expected_utf8 [$];
      int unsigned   errors, checked, pairs, texts, bytes_in;

      function bit byte_fits(int pos, logic [7:0] b);
         case (pos)
            0, 3: return b == SURR_LEAD;
            1:    return b >= HIGH_FIRST && b <= HIGH_LAST;
            4:    return b >= LOW_FIRST && b <= LOW_LAST;
            2, 5: return b >= TRAIL_FIRST && b <= TRAIL_LAST;
            default: return 1'b0;
         endcase
      endfunction

      // Do n bytes of c, starting at from, open a surrogate pair?
      function bit starts_pair(logic [7:0] c [PAIR_BYTES], int from, int n);
         for (int i = 0; i < n; i++)
            if (!byte_fits(i, c[from + i])) return 1'b0;
         return 1'b1;
      endfunction

      function void owe(logic [7:0] b);
         expected_utf8.push_back('{data: b, last: 1'b0, status: 1'b0});
      endfunction

      // Note one accepted text byte and queue the UTF-8 bytes it releases.
      function void note_text_byte(logic [7:0] b, logic eot);
         logic [7:0]  cand [PAIR_BYTES];
         int          len, start, n;
         int unsigned hi, lo, cp;
         n = 0;
         bytes_in++;
         for (int i = 0; i < held_n; i++) cand[i] = held[i];
         cand[held_n] = b;
         len = held_n + 1;
         if (len == PAIR_BYTES && starts_pair(cand, 0, len)) begin
            hi = {cand[0][3:0], cand[1][5:0], cand[2][5:0]};
            lo = {cand[3][3:0], cand[4][5:0], cand[5][5:0]};
            cp = (hi - HIGH_BASE) * HALF_SPAN + (lo - LOW_BASE) + SUPP_START;
            owe({5'b11110, cp[20:18]});
            owe({2'b10, cp[17:12]});
            owe({2'b10, cp[11:6]});
            owe({2'b10, cp[5:0]});
            n = 4;
            pairs++;
            pair_seen = 1'b1;
            held_n = 0;
         end else begin
            // release from the front until the rest could still open a pair
            start = 0;
            while (start < len && !starts_pair(cand, start, len - start)) begin
               owe(cand[start]);
               n++;
               start++;
            end
            held_n = len - start;
            for (int i = 0; i < held_n; i++) held[i] = cand[start + i];
         end
         if (eot) begin
            for (int i = 0; i < held_n; i++) begin
               owe(held[i]);
               n++;
            end
            if (n > 0) begin
               expected_utf8[$].last   = 1'b1;
               expected_utf8[$].status = !pair_seen;
            end
            held_n = 0;
            pair_seen = 1'b0;
            texts++;
         end
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h",
                     $time, field, want, got);
         end
      endfunction

      // Check one accepted output word against the oldest owed byte.
      function void check_utf8_byte(logic [7:0] b, logic last, logic status);
         utf8_word_type want;
         checked++;
         if (expected_utf8.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: expected none, actual byte 0x%02h last %0b",
                     $time, b, last);
            return;
         end
         want = expected_utf8.pop_front();
         compare_field("out_byte", want.data, b);
         compare_field("out_last", {7'b0, want.last}, {7'b0, last});
         compare_field("conv_status", {7'b0, want.status}, {7'b0, status});
      endfunction

      function int pending();
         return expected_utf8.size();
      endfunction
   endclass

   // Drive every input to a known value from time zero
   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte   = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_conv_status;

   int unsigned         send_idle_pct = 0;
   int unsigned         rsp_stall_pct = 0;
   text_word_type       text_words [$];
   utf8_scoreboard_type sb = new();

   cesu8_surrogate_to_utf8_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_last    (rsp_out_last),
      .rsp_conv_status (rsp_conv_status)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the output channel at the rate of the current phase; update on the
   // falling edge so the block sees a settled ready at the next rising edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Sample both handshakes at the rising edge. Reads here see the values from
   // before the edge, so the block's own updates at this edge cannot race them.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_text_byte(req_text_byte, req_end_of_text);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_utf8_byte(rsp_out_byte, rsp_out_last, rsp_conv_status);
   end

   function automatic void push_word(logic [7:0] b, logic eot);
      text_words.push_back('{data: b, eot: eot});
   endfunction

   // Build one random text. Half of the pieces are well-formed pairs with random payload
   // bits; the rest are pairs cut short by a random byte, stray lead bytes (alone
   // or doubled, to force a restart on a later lead) and plain random bytes.
   function automatic void add_text();
      int         pieces, kind, cut;
      logic [7:0] pair [PAIR_BYTES];
      pieces = $urandom_range(8, 1);
      for (int p = 0; p < pieces; p++) begin
         kind    = $urandom_range(99);
         pair[0] = SURR_LEAD;
         pair[1] = HIGH_FIRST + 8'($urandom_range(15));
         pair[2] = TRAIL_FIRST + 8'($urandom_range(63));
         pair[3] = SURR_LEAD;
         pair[4] = LOW_FIRST + 8'($urandom_range(15));
         pair[5] = TRAIL_FIRST + 8'($urandom_range(63));
         if (kind < 50) begin
            for (int k = 0; k < PAIR_BYTES; k++) push_word(pair[k], 1'b0);
         end else if (kind < 70) begin
            cut = $urandom_range(PAIR_BYTES - 1, 1);
            for (int k = 0; k < cut; k++) push_word(pair[k], 1'b0);
            push_word(8'($urandom_range(255)), 1'b0);
         end else if (kind < 82) begin
            push_word(SURR_LEAD, 1'b0);
            if ($urandom_range(1)) push_word(SURR_LEAD, 1'b0);
         end else begin
            push_word(8'($urandom_range(255)), 1'b0);
         end
      end
      text_words[$].eot = 1'b1;
   endfunction

   // Offer one word from a falling edge; hold it until accepted, then return at
   // the next falling edge with valid still high.
   task automatic send_word(text_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= w.data;
      req_end_of_text <= w.eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Run one idling pattern: top up the word list with random texts, send it
   // all, then hold the sender off until every owed byte has come back.
   task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int n_words);
      text_word_type w;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (text_words.size() < n_words) add_text();
      while (text_words.size() != 0) begin
         w = text_words.pop_front();
         send_word(w);
      end
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed texts: byte extremes, then the lowest and highest supplementary
      // code points with the second pair completing on the final byte.
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'hED, 1'b0); push_word(8'hA0, 1'b0); push_word(8'h80, 1'b0);
      push_word(8'hED, 1'b0); push_word(8'hB0, 1'b0); push_word(8'h80, 1'b0);
      push_word(8'hED, 1'b0); push_word(8'hAF, 1'b0); push_word(8'hBF, 1'b0);
      push_word(8'hED, 1'b0); push_word(8'hBF, 1'b0); push_word(8'hBF, 1'b1);
      // Broken match that restarts on the second lead, then end of text with
      // four bytes still held and no pair found.
      push_word(8'hED, 1'b0); push_word(8'hA0, 1'b0); push_word(8'hED, 1'b0);
      push_word(8'hA5, 1'b0); push_word(8'h90, 1'b0); push_word(8'hED, 1'b1);
      // Match broken at the low surrogate byte: all five bytes come out as-is.
      push_word(8'hED, 1'b0); push_word(8'hA0, 1'b0); push_word(8'h80, 1'b0);
      push_word(8'hED, 1'b0); push_word(8'hC0, 1'b1);

      run_phase(0, 0, 125);
      run_phase(78, 0, 120);
      run_phase(0, 78, 120);
      run_phase(10, 10, 120);

      // Drain, then give the block time to show any stray word
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Run covered %0d text bytes in %0d texts with %0d surrogate pairs converted,",
               sb.bytes_in, sb.texts, sb.pairs);
      $display("and %0d UTF-8 bytes checked under four idle and stall patterns.", sb.checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Timeout with %0d bytes still owed", sb.pending());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
